// ----- sv/keypad_calculator_controller_assert.svh -----
// assertion macros for the keypad calculator controller
// expects clk and rst_n in the scope of each use
`ifndef KEYPAD_CALCULATOR_CONTROLLER_ASSERT_SVH
`define KEYPAD_CALCULATOR_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define KCC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KCC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/kcc_pkg.sv -----
// types and constants of the keypad calculator controller
// no dependencies
package kcc_pkg;

  localparam int OPND_W   = 30;
  localparam int RES_W    = 32;
  localparam int KEY_W    = 8;
  localparam int CFG_W    = 4;
  localparam int DIV_STEPS = OPND_W;
  localparam int DCNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_W-1:0] DIGITS_RESET = 4'd5;
  localparam logic [CFG_W-1:0] DIGITS_MIN   = 4'd1;
  localparam logic [CFG_W-1:0] DIGITS_MAX   = 4'd9;

  localparam logic [KEY_W-1:0] KEY_PLUS  = 8'h2B;
  localparam logic [KEY_W-1:0] KEY_MINUS = 8'h2D;
  localparam logic [KEY_W-1:0] KEY_STAR  = 8'h2A;
  localparam logic [KEY_W-1:0] KEY_SLASH = 8'h2F;
  localparam logic [KEY_W-1:0] KEY_EQUAL = 8'h3D;
  localparam logic [KEY_W-1:0] KEY_RESET = 8'h72;
  localparam logic [KEY_W-1:0] KEY_0     = 8'h30;
  localparam logic [KEY_W-1:0] KEY_9     = 8'h39;

  typedef enum logic [1:0] {
    KIND_IGNORED = 2'd0,
    KIND_ECHO    = 2'd1,
    KIND_RESULT  = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KC_DIGIT,
    KC_OP,
    KC_EQ,
    KC_RST,
    KC_OTHER
  } key_class_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic  load_key;
    logic  acc_first;
    logic  acc_second;
    logic  latch_op;
    logic  eq_start;
    logic  div_step;
    logic  clear_all;
    logic  res_load;
    kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    key_class_t key_class;
    logic       first_complete;
    logic       operator_latched;
    logic       second_complete;
    logic       showing_result;
    op_t        op_code;
    logic       div_done;
  } st_t;

endpackage

// ----- sv/kcc_key_if.sv -----
// key request channel of the keypad calculator controller
// depends on kcc_pkg
interface kcc_key_if;
  logic                       valid;
  logic                       ready;
  logic [kcc_pkg::KEY_W-1:0]  key_code;

  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

// ----- sv/kcc_res_if.sv -----
// result request channel of the keypad calculator controller
// depends on kcc_pkg
interface kcc_res_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       out_kind;
  logic [kcc_pkg::KEY_W-1:0]        echo_char;
  logic signed [kcc_pkg::RES_W-1:0] result_value;
  logic                             div_by_zero;

  modport source (output valid, output out_kind, output echo_char, output result_value,
                  output div_by_zero, input ready);
  modport sink (input valid, input out_kind, input echo_char, input result_value,
                input div_by_zero, output ready);
endinterface

// ----- sv/kcc_div.sv -----
// restoring divider, one quotient bit per cycle while step is held
// depends on kcc_pkg
module kcc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         step,
  input  logic [kcc_pkg::OPND_W-1:0]   dividend,
  input  logic [kcc_pkg::OPND_W-1:0]   divisor,
  output logic [kcc_pkg::OPND_W-1:0]   quotient,
  output logic                         done
);

  logic [kcc_pkg::OPND_W-1:0]  rem_r, rem_nxt;
  logic [kcc_pkg::OPND_W-1:0]  quo_r, quo_nxt;
  logic [kcc_pkg::DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [kcc_pkg::OPND_W:0]    shifted;
  logic [kcc_pkg::OPND_W+1:0]  diff;

  always_comb begin
    shifted = {rem_r, quo_r[kcc_pkg::OPND_W-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = '0;
    end else if (step) begin
      if (diff[kcc_pkg::OPND_W+1]) begin
        rem_nxt = shifted[kcc_pkg::OPND_W-1:0];
        quo_nxt = {quo_r[kcc_pkg::OPND_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[kcc_pkg::OPND_W-1:0];
        quo_nxt = {quo_r[kcc_pkg::OPND_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign done     = (cnt_r == kcc_pkg::DCNT_W'(kcc_pkg::DIV_STEPS));

endmodule

// ----- sv/kcc_dp.sv -----
// datapath: operand entry, flags, arithmetic and the output register
// depends on kcc_pkg and kcc_div
module kcc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kcc_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic [kcc_pkg::KEY_W-1:0]         key_code,
  input  kcc_pkg::cmd_t                     cmd,
  output kcc_pkg::st_t                      st,
  output logic [1:0]                        out_kind,
  output logic [kcc_pkg::KEY_W-1:0]         echo_char,
  output logic signed [kcc_pkg::RES_W-1:0]  result_value,
  output logic                              div_by_zero
);

  localparam int OW = kcc_pkg::OPND_W;
  localparam int RW = kcc_pkg::RES_W;
  localparam int CW = kcc_pkg::CFG_W;

  logic [CW-1:0]                max_digits_r;
  logic [kcc_pkg::KEY_W-1:0]    key_r;
  logic [OW-1:0]                first_r, first_nxt;
  logic [OW-1:0]                second_r, second_nxt;
  logic [CW-1:0]                fcnt_r, fcnt_nxt;
  logic [CW-1:0]                scnt_r, scnt_nxt;
  kcc_pkg::op_t                 op_r, op_nxt;
  logic                         fcomp_r, fcomp_nxt;
  logic                         latched_r, latched_nxt;
  logic                         scomp_r, scomp_nxt;
  logic                         showing_r, showing_nxt;
  logic [RW-1:0]                arith_r, arith_nxt;
  logic [1:0]                   kind_r;
  logic [kcc_pkg::KEY_W-1:0]    echo_r;
  logic [RW-1:0]                value_r, value_nxt;
  logic                         dz_r;

  logic [CW-1:0]                lim;
  logic [CW-1:0]                digit;
  logic [OW+3:0]                first_acc;
  logic [OW+3:0]                second_acc;
  logic [CW-1:0]                fcnt_inc;
  logic [CW-1:0]                scnt_inc;
  logic [2*OW-1:0]              prod;
  logic                         dz;
  logic [OW-1:0]                quotient;
  logic                         div_done;
  kcc_pkg::key_class_t          key_class;
  kcc_pkg::op_t                 key_op;

  kcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.eq_start),
    .step     (cmd.div_step),
    .dividend (first_r),
    .divisor  (second_r),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    priority if (max_digits_r < kcc_pkg::DIGITS_MIN) lim = kcc_pkg::DIGITS_MIN;
    else if (max_digits_r > kcc_pkg::DIGITS_MAX) lim = kcc_pkg::DIGITS_MAX;
    else lim = max_digits_r;
  end

  always_comb begin
    priority if (key_r >= kcc_pkg::KEY_0 && key_r <= kcc_pkg::KEY_9) begin
      key_class = kcc_pkg::KC_DIGIT;
    end else if (key_r == kcc_pkg::KEY_PLUS || key_r == kcc_pkg::KEY_MINUS ||
                 key_r == kcc_pkg::KEY_STAR || key_r == kcc_pkg::KEY_SLASH) begin
      key_class = kcc_pkg::KC_OP;
    end else if (key_r == kcc_pkg::KEY_EQUAL) begin
      key_class = kcc_pkg::KC_EQ;
    end else if (key_r == kcc_pkg::KEY_RESET) begin
      key_class = kcc_pkg::KC_RST;
    end else begin
      key_class = kcc_pkg::KC_OTHER;
    end
    priority if (key_r == kcc_pkg::KEY_PLUS) key_op = kcc_pkg::OP_ADD;
    else if (key_r == kcc_pkg::KEY_MINUS) key_op = kcc_pkg::OP_SUB;
    else if (key_r == kcc_pkg::KEY_STAR) key_op = kcc_pkg::OP_MUL;
    else key_op = kcc_pkg::OP_DIV;
  end

  always_comb begin
    digit      = CW'(key_r - kcc_pkg::KEY_0);
    first_acc  = (OW+4)'(first_r) * (OW+4)'(10) + (OW+4)'(digit);
    second_acc = (OW+4)'(second_r) * (OW+4)'(10) + (OW+4)'(digit);
    fcnt_inc   = fcnt_r + 1'b1;
    scnt_inc   = scnt_r + 1'b1;
    prod       = (2*OW)'(first_r) * (2*OW)'(second_r);
    dz         = (op_r == kcc_pkg::OP_DIV) && (second_r == '0);

    first_nxt   = first_r;
    second_nxt  = second_r;
    fcnt_nxt    = fcnt_r;
    scnt_nxt    = scnt_r;
    op_nxt      = op_r;
    fcomp_nxt   = fcomp_r;
    latched_nxt = latched_r;
    scomp_nxt   = scomp_r;
    showing_nxt = showing_r;
    priority if (cmd.clear_all) begin
      first_nxt   = '0;
      second_nxt  = '0;
      fcnt_nxt    = '0;
      scnt_nxt    = '0;
      op_nxt      = kcc_pkg::OP_ADD;
      fcomp_nxt   = 1'b0;
      latched_nxt = 1'b0;
      scomp_nxt   = 1'b0;
      showing_nxt = 1'b0;
    end else if (cmd.acc_first) begin
      first_nxt = first_acc[OW-1:0];
      fcnt_nxt  = fcnt_inc;
      if (fcnt_inc >= lim) fcomp_nxt = 1'b1;
    end else if (cmd.acc_second) begin
      second_nxt = second_acc[OW-1:0];
      scnt_nxt   = scnt_inc;
      if (scnt_inc >= lim) scomp_nxt = 1'b1;
    end else if (cmd.latch_op) begin
      op_nxt      = key_op;
      latched_nxt = 1'b1;
      fcomp_nxt   = 1'b1;
    end else if (cmd.eq_start) begin
      scomp_nxt   = 1'b1;
      showing_nxt = 1'b1;
    end else begin
      showing_nxt = showing_r;
    end

    unique case (op_r)
      kcc_pkg::OP_ADD: arith_nxt = RW'(first_r) + RW'(second_r);
      kcc_pkg::OP_SUB: arith_nxt = RW'(first_r) - RW'(second_r);
      kcc_pkg::OP_MUL: arith_nxt = prod[RW-1:0];
      default:         arith_nxt = '0;
    endcase

    if (op_r == kcc_pkg::OP_DIV) begin
      value_nxt = dz ? '0 : RW'(quotient);
    end else begin
      value_nxt = arith_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_digits_r <= kcc_pkg::DIGITS_RESET;
      first_r      <= '0;
      second_r     <= '0;
      fcnt_r       <= '0;
      scnt_r       <= '0;
      op_r         <= kcc_pkg::OP_ADD;
      fcomp_r      <= 1'b0;
      latched_r    <= 1'b0;
      scomp_r      <= 1'b0;
      showing_r    <= 1'b0;
    end else begin
      if (cfg_we) max_digits_r <= cfg_wdata;
      first_r   <= first_nxt;
      second_r  <= second_nxt;
      fcnt_r    <= fcnt_nxt;
      scnt_r    <= scnt_nxt;
      op_r      <= op_nxt;
      fcomp_r   <= fcomp_nxt;
      latched_r <= latched_nxt;
      scomp_r   <= scomp_nxt;
      showing_r <= showing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) key_r <= key_code;
    if (cmd.eq_start) arith_r <= arith_nxt;
    if (cmd.res_load) begin
      kind_r  <= cmd.res_kind;
      echo_r  <= (cmd.res_kind == kcc_pkg::KIND_ECHO) ? key_r : '0;
      value_r <= (cmd.res_kind == kcc_pkg::KIND_RESULT) ? value_nxt : '0;
      dz_r    <= (cmd.res_kind == kcc_pkg::KIND_RESULT) && dz;
    end
  end

  always_comb begin
    st.key_class        = key_class;
    st.first_complete   = fcomp_r;
    st.operator_latched = latched_r;
    st.second_complete  = scomp_r;
    st.showing_result   = showing_r;
    st.op_code          = op_r;
    st.div_done         = div_done;
  end

  assign out_kind     = kind_r;
  assign echo_char    = echo_r;
  assign result_value = value_r;
  assign div_by_zero  = dz_r;

endmodule

// ----- sv/kcc_ctrl.sv -----
// controller state machine: request handshakes and datapath sequencing
// depends on kcc_pkg
module kcc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  kcc_pkg::st_t   st,
  output kcc_pkg::cmd_t  cmd
);

  kcc_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    slot_free = !out_valid_r || out_ready;
    unique case (state_r)
      kcc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_key = 1'b1;
          state_nxt    = kcc_pkg::S_DECODE;
        end
      end
      kcc_pkg::S_DECODE: begin
        if (slot_free) begin
          state_nxt    = kcc_pkg::S_IDLE;
          cmd.res_load = 1'b1;
          cmd.res_kind = kcc_pkg::KIND_IGNORED;
          priority if (st.showing_result) begin
            if (st.key_class == kcc_pkg::KC_RST) begin
              cmd.clear_all = 1'b1;
              cmd.res_kind  = kcc_pkg::KIND_CLEAR;
            end
          end else if (st.key_class == kcc_pkg::KC_DIGIT) begin
            if (!st.first_complete) begin
              cmd.acc_first = 1'b1;
              cmd.res_kind  = kcc_pkg::KIND_ECHO;
            end else if (st.operator_latched && !st.second_complete) begin
              cmd.acc_second = 1'b1;
              cmd.res_kind   = kcc_pkg::KIND_ECHO;
            end
          end else if (st.key_class == kcc_pkg::KC_OP) begin
            if (!st.operator_latched) begin
              cmd.latch_op = 1'b1;
              cmd.res_kind = kcc_pkg::KIND_ECHO;
            end
          end else if (st.key_class == kcc_pkg::KC_EQ && st.first_complete &&
                       st.operator_latched) begin
            cmd.res_load = 1'b0;
            cmd.eq_start = 1'b1;
            state_nxt    = (st.op_code == kcc_pkg::OP_DIV) ? kcc_pkg::S_DIV
                                                           : kcc_pkg::S_EMIT;
          end else begin
            cmd.res_kind = kcc_pkg::KIND_IGNORED;
          end
        end
      end
      kcc_pkg::S_DIV: begin
        if (st.div_done) begin
          state_nxt = kcc_pkg::S_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      kcc_pkg::S_EMIT: begin
        if (slot_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = kcc_pkg::KIND_RESULT;
          state_nxt    = kcc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kcc_pkg::S_IDLE;
      end
    endcase

    priority if (cmd.res_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kcc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/keypad_calculator_controller.sv -----
// keypad calculator controller: a key request is taken in IDLE and decoded in DECODE, where
// its result is loaded into the output register, and only then is the next key taken; '='
// with + - * goes through DECODE and EMIT, '/' through DECODE, DIV and EMIT, the restoring
// divider retiring one quotient bit per cycle in DIV; a stalled result holds the next key;
// rst_n is synchronous, active low: clears operands, flags and output valid, max_digits
// to 5; depends on kcc_pkg, the interfaces, kcc_ctrl and kcc_dp
`include "keypad_calculator_controller_assert.svh"

module keypad_calculator_controller (
  input  logic                         clk,
  input  logic                         rst_n,
  kcc_key_if.sink                      in_ch,
  kcc_res_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [kcc_pkg::CFG_W-1:0]    cfg_wdata
);

  kcc_pkg::cmd_t cmd;
  kcc_pkg::st_t  st;

  kcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  kcc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .key_code     (in_ch.key_code),
    .cmd          (cmd),
    .st           (st),
    .out_kind     (out_ch.out_kind),
    .echo_char    (out_ch.echo_char),
    .result_value (out_ch.result_value),
    .div_by_zero  (out_ch.div_by_zero)
  );

  // output register is only reloaded once its request has left
  `KCC_ASSERT_IMP(a_load_slot, cmd.res_load, !out_ch.valid || out_ch.ready,
                  "result overwritten")
  // a zero divisor always goes out as a result of zero
  `KCC_ASSERT_IMP(a_dz_zero, out_ch.valid && out_ch.div_by_zero,
                  out_ch.out_kind == kcc_pkg::KIND_RESULT && out_ch.result_value == 0,
                  "bad div by zero result")
  // an equals key locks the calculator until reset key
  `KCC_ASSERT_NXT(a_eq_locks, cmd.eq_start, st.showing_result && st.second_complete,
                  "equals did not lock")
  // results only leave while the calculator is locked
  `KCC_ASSERT_IMP(a_res_locked, out_ch.valid && out_ch.out_kind == kcc_pkg::KIND_RESULT,
                  st.showing_result, "result while entering operands")

endmodule

// ----- verif/kcc_checker.sv -----
// response checker for the keypad calculator controller: watches key, result and config ports
// keeps its own calculator state and compares every result request with the predicted one
// depends on kcc_pkg, kcc_key_if and kcc_res_if
module kcc_checker
  import kcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  kcc_key_if               key_bus,
  kcc_res_if               res_bus,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               outstanding,
  output int               failures
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t                   kind;
    logic [KEY_W-1:0]        echo;
    logic signed [RES_W-1:0] value;
    logic                    dz;
  } response_t;

  logic [CFG_W-1:0]  digit_setting;
  logic [OPND_W-1:0] opnd_a;
  logic [OPND_W-1:0] opnd_b;
  logic [3:0]        cnt_a;
  logic [3:0]        cnt_b;
  op_t               op_sel;
  logic              a_done;
  logic              op_held;
  logic              b_done;
  logic              showing;
  response_t         pending_responses[$];

  function automatic void clear_calc();
    opnd_a  = '0;
    opnd_b  = '0;
    cnt_a   = '0;
    cnt_b   = '0;
    op_sel  = OP_ADD;
    a_done  = 1'b0;
    op_held = 1'b0;
    b_done  = 1'b0;
    showing = 1'b0;
  endfunction

  function automatic response_t calc_response(input logic [KEY_W-1:0] key);
    logic [CFG_W-1:0]    lim;
    logic [3:0]          digit;
    logic [2*OPND_W-1:0] prod;
    response_t           r;
    lim = (digit_setting < DIGITS_MIN) ? DIGITS_MIN :
          (digit_setting > DIGITS_MAX) ? DIGITS_MAX : digit_setting;
    digit = 4'(key - KEY_0);
    r = '{KIND_IGNORED, '0, '0, 1'b0};
    if (showing) begin
      if (key == KEY_RESET) begin
        clear_calc();
        r.kind = KIND_CLEAR;
      end
    end else if (key >= KEY_0 && key <= KEY_9) begin
      if (!a_done) begin
        opnd_a = opnd_a * OPND_W'(10) + OPND_W'(digit);
        cnt_a = cnt_a + 4'd1;
        if (cnt_a >= lim) a_done = 1'b1;
        r.kind = KIND_ECHO;
        r.echo = key;
      end else if (op_held && !b_done) begin
        opnd_b = opnd_b * OPND_W'(10) + OPND_W'(digit);
        cnt_b = cnt_b + 4'd1;
        if (cnt_b >= lim) b_done = 1'b1;
        r.kind = KIND_ECHO;
        r.echo = key;
      end
    end else if (key == KEY_PLUS || key == KEY_MINUS || key == KEY_STAR || key == KEY_SLASH) begin
      if (!op_held) begin
        case (key)
          KEY_PLUS:  op_sel = OP_ADD;
          KEY_MINUS: op_sel = OP_SUB;
          KEY_STAR:  op_sel = OP_MUL;
          default:   op_sel = OP_DIV;
        endcase
        op_held = 1'b1;
        a_done = 1'b1;
        r.kind = KIND_ECHO;
        r.echo = key;
      end
    end else if (key == KEY_EQUAL && a_done && op_held) begin
      b_done = 1'b1;
      showing = 1'b1;
      r.kind = KIND_RESULT;
      case (op_sel)
        OP_ADD: r.value = RES_W'(opnd_a) + RES_W'(opnd_b);
        OP_SUB: r.value = RES_W'(opnd_a) - RES_W'(opnd_b);
        OP_MUL: begin
          prod = (2*OPND_W)'(opnd_a) * (2*OPND_W)'(opnd_b);
          r.value = prod[RES_W-1:0];
        end
        default: begin
          if (opnd_b == '0) r.dz = 1'b1;
          else r.value = RES_W'(opnd_a / opnd_b);
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    response_t want;
    if (!rst_n) begin
      digit_setting = DIGITS_RESET;
      clear_calc();
      pending_responses.delete();
      failures = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (pending_responses.size() == 0) begin
          $display("%0t: unexpected result: expected none, got kind %0d char %h value %0d dz %b",
                   $time, res_bus.out_kind, res_bus.echo_char, res_bus.result_value,
                   res_bus.div_by_zero);
          failures++;
        end else begin
          want = pending_responses.pop_front();
          if (res_bus.out_kind !== want.kind || res_bus.echo_char !== want.echo ||
              res_bus.result_value !== want.value || res_bus.div_by_zero !== want.dz) begin
            $display("%0t: result mismatch: expected kind %0d char %h value %0d dz %b",
                     $time, want.kind, want.echo, want.value, want.dz);
            $display("%0t:                  got kind %0d char %h value %0d dz %b",
                     $time, res_bus.out_kind, res_bus.echo_char, res_bus.result_value,
                     res_bus.div_by_zero);
            failures++;
          end
        end
      end
      if (cfg_we) digit_setting = cfg_wdata;
      if (key_bus.valid && key_bus.ready) begin
        pending_responses.push_back(calc_response(key_bus.key_code));
      end
    end
    outstanding <= pending_responses.size();
  end

endmodule

// ----- verif/testbench.sv -----
// top of the keypad calculator controller testbench: clock, reset, key and config stimulus
// results are checked by kcc_checker; depends on it, kcc_pkg, the interfaces and the DUT
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kcc_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               outstanding;
  int               failures;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               keys_sent;
  logic [CFG_W-1:0] digit_cfg;

  kcc_key_if key_bus();
  kcc_res_if res_bus();

  keypad_calculator_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (key_bus),
    .out_ch    (res_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  kcc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .key_bus     (key_bus),
    .res_bus     (res_bus),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .failures    (failures)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic press_key(input logic [KEY_W-1:0] key);
    if ($urandom_range(99) < send_idle_pct) begin
      key_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    key_bus.valid <= 1'b1;
    key_bus.key_code <= key;
    @(posedge clk);
    while (!key_bus.ready) @(posedge clk);
    keys_sent++;
  endtask

  task automatic type_keys(input string s);
    for (int i = 0; i < s.len(); i++) press_key(s[i]);
  endtask

  // hold off requests until every result is back
  task automatic settle();
    key_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_digits(input logic [CFG_W-1:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    digit_cfg = value;
  endtask

  function automatic logic [KEY_W-1:0] random_digit();
    return KEY_0 + KEY_W'($urandom_range(9));
  endfunction

  function automatic logic [KEY_W-1:0] pick_operator();
    case ($urandom_range(3))
      0:       return KEY_PLUS;
      1:       return KEY_MINUS;
      2:       return KEY_STAR;
      default: return KEY_SLASH;
    endcase
  endfunction

  // mostly complete calculations with random content, some noise and broken entries
  task automatic random_entry();
    int lim;
    lim = int'((digit_cfg < DIGITS_MIN) ? DIGITS_MIN :
               (digit_cfg > DIGITS_MAX) ? DIGITS_MAX : digit_cfg);
    if ($urandom_range(99) < 12) begin
      press_key(KEY_W'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(lim + 1)) press_key(random_digit());
      if ($urandom_range(99) < 90) press_key(pick_operator());
      if ($urandom_range(99) < 10) press_key(pick_operator());
      repeat ($urandom_range(lim + 1)) press_key(random_digit());
      if ($urandom_range(99) < 10) press_key(pick_operator());
      if ($urandom_range(99) < 88) press_key(KEY_EQUAL);
      repeat ($urandom_range(2)) press_key(KEY_W'($urandom_range(255)));
      if ($urandom_range(99) < 85) press_key(KEY_RESET);
    end
  endtask

  initial begin
    int digit_plan[6];
    int target;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    key_bus.valid = 1'b0;
    key_bus.key_code = '0;
    res_bus.ready = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 51;
    keys_sent = 0;
    digit_cfg = DIGITS_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    type_keys("123456-+999999=5r");
    press_key(8'h00);
    press_key(KEY_RESET);
    press_key(KEY_EQUAL);
    press_key(KEY_SLASH);
    press_key(KEY_EQUAL);
    press_key(KEY_RESET);
    press_key(8'hFF);
    // partial operand left in place so the lowered limit takes effect mid entry
    type_keys("12");

    digit_plan = '{1, 9, 15, 0, 5, 9};
    digit_plan[4] = $urandom_range(2, 8);
    foreach (digit_plan[p]) begin
      write_digits(CFG_W'(digit_plan[p]));
      send_idle_pct = (p < 2) ? 15 : (p < 4) ? 51 : 0;
      recv_idle_pct = (p < 2) ? 51 : (p < 4) ? 15 : 0;
      target = keys_sent + 115;
      while (keys_sent < target) random_entry();
    end
    settle();

    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
